// ===== sv/bad_block_remap_table_assert.svh =====
// Assertion macros used by the checker of the bad block remap table.
`ifndef BAD_BLOCK_REMAP_TABLE_ASSERT_SVH
`define BAD_BLOCK_REMAP_TABLE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBRT_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bad block remap table check failed");

// The consequent must hold in the cycle after the antecedent.
`define BBRT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bad block remap table check failed");

`endif

// ===== sv/bbrt_pkg.sv =====
// Shared constants, codes and types of the bad block remap table.
package bbrt_pkg;

    // PAGES_PER_BLOCK must be a power of two; block rounding is a mask.
    localparam int MAX_ENTRIES     = 256;
    localparam int PAGES_PER_BLOCK = 64;

    localparam int ADDR_W     = $clog2(MAX_ENTRIES);
    localparam int CNT_W      = $clog2(MAX_ENTRIES + 1);
    localparam int SECTOR_W   = 32;
    localparam int CMD_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int OUT_BITS   = 1 + SECTOR_W + COUNT_W;
    localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;
    localparam int OUT_MAP_LSB   = 1;
    localparam int OUT_COUNT_LSB = 1 + SECTOR_W;

    typedef logic [CMD_W-1:0]    cmd_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [2:0]          idx_op_t;

    localparam cmd_t CMD_MARK      = 3'd0;
    localparam cmd_t CMD_REGISTER  = 3'd1;
    localparam cmd_t CMD_QUERY     = 3'd2;
    localparam cmd_t CMD_TRANSLATE = 3'd3;
    localparam cmd_t CMD_CLEAR     = 3'd4;

    localparam status_t ST_INSERTED  = 3'd0;
    localparam status_t ST_DUPLICATE = 3'd1;
    localparam status_t ST_FULL      = 3'd2;
    localparam status_t ST_REFUSED   = 3'd3;
    localparam status_t ST_ANSWERED  = 3'd4;
    localparam status_t ST_CLEARED   = 3'd5;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCAN_DONE     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RUNTIME_REGEN = 2'd2;

    localparam idx_op_t IDX_HOLD = 3'd0;
    localparam idx_op_t IDX_ZERO = 3'd1;
    localparam idx_op_t IDX_INC  = 3'd2;
    localparam idx_op_t IDX_DEC  = 3'd3;
    localparam idx_op_t IDX_LAST = 3'd4;

    localparam logic [SECTOR_W-1:0] BLOCK_MASK = ~(SECTOR_W'(PAGES_PER_BLOCK - 1));
    localparam logic [SECTOR_W-1:0] STEP_BLOCK = SECTOR_W'(PAGES_PER_BLOCK);
    localparam logic [SECTOR_W-1:0] STEP_PAGE  = SECTOR_W'(1);
    localparam logic [CNT_W-1:0]    FULL_COUNT = CNT_W'(MAX_ENTRIES);

    typedef struct packed {
        logic    start;
        logic    clear_tbl;
        logic    set_status;
        status_t status_code;
        logic    latch_pos;
        idx_op_t idx_op;
        logic    wr_shift;
        logic    wr_insert;
        logic    set_bad;
        logic    set_mapped;
        logic    acc_add;
        logic    load_out;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic reg_allowed;
        logic scan_end;
        logic scan_stop;
        logic scan_hit;
        logic at_pos;
        logic walk_stop;
        logic out_free;
    } dp_stat_t;

endpackage

// ===== sv/bbrt_ctrl.sv =====
// Controller state machine that sequences scans, shifts, inserts and walks.
module bbrt_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  bbrt_pkg::cmd_t    in_cmd,
    output logic              in_ready,
    input  bbrt_pkg::dp_stat_t st,
    output bbrt_pkg::dp_cmd_t  cmd
);
    import bbrt_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SCAN   = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_INSERT = 3'd3;
    localparam logic [2:0] S_WALK   = 3'd4;
    localparam logic [2:0] S_FINISH = 3'd5;

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic       is_query_reg;
    logic       is_query_next;

    assign in_ready = (state_reg == S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            is_query_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            is_query_reg <= is_query_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        is_query_next   = is_query_reg;
        cmd             = '0;
        cmd.idx_op      = IDX_HOLD;
        cmd.status_code = ST_REFUSED;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start     = 1'b1;
                    cmd.idx_op    = IDX_ZERO;
                    is_query_next = (in_cmd == CMD_QUERY);
                    unique case (in_cmd) inside
                        CMD_MARK, CMD_REGISTER:
                        begin
                            if ((in_cmd == CMD_REGISTER) && !st.reg_allowed)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = ST_REFUSED;
                                state_next      = S_FINISH;
                            end
                            else if (st.full)
                            begin
                                cmd.set_status  = 1'b1;
                                cmd.status_code = ST_FULL;
                                state_next      = S_FINISH;
                            end
                            else
                            begin
                                state_next = S_SCAN;
                            end
                        end
                        CMD_QUERY:
                        begin
                            state_next = S_SCAN;
                        end
                        CMD_TRANSLATE:
                        begin
                            state_next = S_WALK;
                        end
                        CMD_CLEAR:
                        begin
                            cmd.clear_tbl   = 1'b1;
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_CLEARED;
                            state_next      = S_FINISH;
                        end
                        default:
                        begin
                            cmd.set_status  = 1'b1;
                            cmd.status_code = ST_REFUSED;
                            state_next      = S_FINISH;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (st.scan_stop)
                begin
                    if (is_query_reg)
                    begin
                        cmd.set_bad     = 1'b1;
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_ANSWERED;
                        state_next      = S_FINISH;
                    end
                    else if (st.scan_hit)
                    begin
                        cmd.set_status  = 1'b1;
                        cmd.status_code = ST_DUPLICATE;
                        state_next      = S_FINISH;
                    end
                    else
                    begin
                        cmd.latch_pos = 1'b1;
                        if (st.scan_end)
                        begin
                            state_next = S_INSERT;
                        end
                        else
                        begin
                            cmd.idx_op = IDX_LAST;
                            state_next = S_SHIFT;
                        end
                    end
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end
            S_SHIFT:
            begin
                cmd.wr_shift = 1'b1;
                if (st.at_pos)
                begin
                    state_next = S_INSERT;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                end
            end
            S_INSERT:
            begin
                cmd.wr_insert   = 1'b1;
                cmd.set_status  = 1'b1;
                cmd.status_code = ST_INSERTED;
                state_next      = S_FINISH;
            end
            S_WALK:
            begin
                if (st.walk_stop)
                begin
                    cmd.set_mapped  = 1'b1;
                    cmd.set_status  = 1'b1;
                    cmd.status_code = ST_ANSWERED;
                    state_next      = S_FINISH;
                end
                else
                begin
                    cmd.acc_add = 1'b1;
                    cmd.idx_op  = IDX_INC;
                end
            end
            S_FINISH:
            begin
                if (st.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== sv/bbrt_dp.sv =====
// Datapath: entry memory, index and accumulator registers, configuration and result register.
module bbrt_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [bbrt_pkg::SECTOR_W-1:0]   in_sector,
    input  logic                            cfg_valid,
    input  logic [bbrt_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic                            cfg_data,
    input  bbrt_pkg::dp_cmd_t               cmd,
    output bbrt_pkg::dp_stat_t              st,
    input  logic                            out_ready,
    output logic                            out_valid,
    output bbrt_pkg::status_t               out_status,
    output logic                            out_bad,
    output logic [bbrt_pkg::SECTOR_W-1:0]   out_mapped,
    output logic [bbrt_pkg::COUNT_W-1:0]    out_count
);
    import bbrt_pkg::*;

    logic [SECTOR_W-1:0] mem [MAX_ENTRIES];

    logic                block_mode_reg;
    logic                scan_done_reg;
    logic                runtime_regen_reg;
    logic [CNT_W-1:0]    total_reg;
    logic [CNT_W-1:0]    total_next;
    logic [CNT_W-1:0]    idx_reg;
    logic [CNT_W-1:0]    idx_next;
    logic [CNT_W-1:0]    pos_reg;
    logic [SECTOR_W-1:0] page_reg;
    logic [SECTOR_W-1:0] acc_reg;
    logic [SECTOR_W-1:0] rdata_reg;
    status_t             res_status_reg;
    logic                res_bad_reg;
    logic [SECTOR_W-1:0] res_mapped_reg;
    logic                out_valid_reg;
    status_t             out_status_reg;
    logic                out_bad_reg;
    logic [SECTOR_W-1:0] out_mapped_reg;
    logic [COUNT_W-1:0]  out_count_reg;

    logic [ADDR_W-1:0]   rd_addr;
    logic                wr_en;
    logic [ADDR_W-1:0]   wr_addr;
    logic [SECTOR_W-1:0] wr_data;
    logic [CNT_W-1:0]    idx_plus1;
    logic [SECTOR_W-1:0] step;

    assign idx_plus1 = idx_reg + CNT_W'(1);
    assign step      = block_mode_reg ? STEP_BLOCK : STEP_PAGE;

    always_comb
    begin
        case (cmd.idx_op)
            IDX_ZERO: idx_next = '0;
            IDX_INC:  idx_next = idx_plus1;
            IDX_DEC:  idx_next = idx_reg - CNT_W'(1);
            IDX_LAST: idx_next = total_reg - CNT_W'(1);
            default:  idx_next = idx_reg;
        endcase
    end

    assign rd_addr = idx_next[ADDR_W-1:0];
    assign wr_en   = cmd.wr_shift | cmd.wr_insert;
    assign wr_addr = cmd.wr_insert ? pos_reg[ADDR_W-1:0] : idx_plus1[ADDR_W-1:0];
    assign wr_data = cmd.wr_insert ? page_reg : rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata_reg <= mem[rd_addr];
    end

    assign st.full        = (total_reg >= FULL_COUNT);
    assign st.reg_allowed = !scan_done_reg || runtime_regen_reg;
    assign st.scan_end    = (idx_reg >= total_reg);
    assign st.scan_stop   = st.scan_end || (rdata_reg >= page_reg);
    assign st.scan_hit    = !st.scan_end && (rdata_reg == page_reg);
    assign st.at_pos      = (idx_reg == pos_reg);
    assign st.walk_stop   = st.scan_end || (rdata_reg > acc_reg);
    assign st.out_free    = !out_valid_reg || out_ready;

    always_comb
    begin
        total_next = total_reg;
        if (cmd.clear_tbl)
        begin
            total_next = '0;
        end
        else if (cmd.wr_insert)
        begin
            total_next = total_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_mode_reg    <= 1'b1;
            scan_done_reg     <= 1'b0;
            runtime_regen_reg <= 1'b0;
            total_reg         <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            total_reg <= total_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    CFG_BLOCK_MODE:    block_mode_reg    <= cfg_data;
                    CFG_SCAN_DONE:     scan_done_reg     <= cfg_data;
                    CFG_RUNTIME_REGEN: runtime_regen_reg <= cfg_data;
                    default:           ;
                endcase
            end
            if (cmd.load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (cmd.start)
        begin
            page_reg       <= block_mode_reg ? (in_sector & BLOCK_MASK) : in_sector;
            acc_reg        <= in_sector;
            res_bad_reg    <= 1'b0;
            res_mapped_reg <= '0;
        end
        if (cmd.acc_add)
        begin
            acc_reg <= acc_reg + step;
        end
        if (cmd.latch_pos)
        begin
            pos_reg <= idx_reg;
        end
        if (cmd.set_status)
        begin
            res_status_reg <= cmd.status_code;
        end
        if (cmd.set_bad)
        begin
            res_bad_reg <= st.scan_hit;
        end
        if (cmd.set_mapped)
        begin
            res_mapped_reg <= acc_reg;
        end
        if (cmd.load_out)
        begin
            out_status_reg <= res_status_reg;
            out_bad_reg    <= res_bad_reg;
            out_mapped_reg <= res_mapped_reg;
            out_count_reg  <= COUNT_W'(total_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_bad    = out_bad_reg;
    assign out_mapped = out_mapped_reg;
    assign out_count  = out_count_reg;

endmodule

// ===== sv/bad_block_remap_table.sv =====
// Top level of the bad block remap table: stream ports, controller and datapath.
// One command is in work at a time; the next transfer is taken once its result is registered.
// Clear, refused and full commands go from the input transfer straight to the result stage;
// query and translate first walk the entries, and mark and register scan and then, if needed,
// shift and insert, the walk reading the entry memory at one entry per cycle.
// Reset (rst_n, asynchronous) empties the table at once and sets block_mode to 1.
module bad_block_remap_table (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bbrt_pkg::SECTOR_W-1:0]     s_tdata,   // sector
    input  logic [bbrt_pkg::CMD_W-1:0]        s_tuser,   // command
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [bbrt_pkg::OUT_DATA_W-1:0]   m_tdata,   // is_bad, mapped_sector, entry_count, zeros
    output logic [bbrt_pkg::STATUS_W-1:0]     m_tuser,   // status
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bbrt_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic                              cfg_data
);
    import bbrt_pkg::*;

    dp_cmd_t             cmd;
    dp_stat_t            st;
    logic                in_ready;
    status_t             out_status;
    logic                out_bad;
    logic [SECTOR_W-1:0] out_mapped;
    logic [COUNT_W-1:0]  out_count;

    assign s_tready  = in_ready;
    assign cfg_ready = 1'b1;

    bbrt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_cmd   (s_tuser),
        .in_ready (in_ready),
        .st       (st),
        .cmd      (cmd)
    );

    bbrt_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_sector  (s_tdata),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .cmd        (cmd),
        .st         (st),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_status (out_status),
        .out_bad    (out_bad),
        .out_mapped (out_mapped),
        .out_count  (out_count)
    );

    assign m_tuser = out_status;
    assign m_tdata = {{(OUT_DATA_W - OUT_BITS){1'b0}}, out_count, out_mapped, out_bad};

endmodule

// ===== sv/bbrt_checker.sv =====
// Port-level checker of the bad block remap table and its bind statement.
`include "bad_block_remap_table_assert.svh"

module bbrt_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [bbrt_pkg::OUT_DATA_W-1:0]   m_tdata,
    input logic [bbrt_pkg::STATUS_W-1:0]     m_tuser
);
    import bbrt_pkg::*;

    logic [COUNT_W-1:0]       count;
    logic [OUT_COUNT_LSB-1:0] low_fields;

    assign count      = m_tdata[OUT_COUNT_LSB +: COUNT_W];
    assign low_fields = m_tdata[OUT_COUNT_LSB-1:0];

    `BBRT_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable({m_tuser, m_tdata}))
    `BBRT_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `BBRT_ASSERT_SAME(a_clear_empties, m_tvalid && (m_tuser == ST_CLEARED), count == '0)
    `BBRT_ASSERT_SAME(a_quiet_fields, m_tvalid && (m_tuser != ST_ANSWERED), low_fields == '0)
    `BBRT_ASSERT_SAME(a_count_bound, m_tvalid, count <= COUNT_W'(MAX_ENTRIES))

endmodule

bind bad_block_remap_table bbrt_checker u_bbrt_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);
